// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the validator parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CJSV_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define CJSV_ASSERT_NEXT(label, clk, rst_n, pre, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (prop)) \
	else $error("assertion failed");
`else
`define CJSV_ASSERT(label, clk, rst_n, prop)
`define CJSV_ASSERT_NEXT(label, clk, rst_n, pre, prop)
`endif
`endif

// ===== rtl/core/cjsv_pkg.sv =====
// Shared constants and types of the canonical JSON stream validator.
`timescale 1ns / 1ps
package cjsv_pkg;
	localparam int LEVELS_DEF    = 8;
	localparam int KEY_BYTES_DEF = 64;
	localparam int CW            = 17;
	localparam int DLW           = 4;
	localparam int SW            = 5;
	localparam logic [CW-1:0] POS_MAX     = 17'h1FFFF;
	localparam logic [CW-1:0] MAXLEN_RST  = 17'd65536;
	localparam logic [DLW-1:0] DEPTH_RST  = 4'd8;

	localparam logic [0:0] REG_MAX_LENGTH  = 1'b0;
	localparam logic [0:0] REG_DEPTH_LIMIT = 1'b1;

	localparam logic [SW-1:0] ST_OK        = 5'd0;
	localparam logic [SW-1:0] ST_VALUE     = 5'd1;
	localparam logic [SW-1:0] ST_KEYSTR    = 5'd2;
	localparam logic [SW-1:0] ST_ESCAPE    = 5'd3;
	localparam logic [SW-1:0] ST_UNPRINT   = 5'd4;
	localparam logic [SW-1:0] ST_UNTERM    = 5'd5;
	localparam logic [SW-1:0] ST_RANGE     = 5'd6;
	localparam logic [SW-1:0] ST_LEADZERO  = 5'd7;
	localparam logic [SW-1:0] ST_FRACTION  = 5'd8;
	localparam logic [SW-1:0] ST_ORDER     = 5'd9;
	localparam logic [SW-1:0] ST_COLON     = 5'd10;
	localparam logic [SW-1:0] ST_SEPARATOR = 5'd11;
	localparam logic [SW-1:0] ST_DEPTH     = 5'd12;
	localparam logic [SW-1:0] ST_ROOT      = 5'd13;
	localparam logic [SW-1:0] ST_TRAILING  = 5'd14;
	localparam logic [SW-1:0] ST_SIZE      = 5'd15;
	localparam logic [SW-1:0] ST_KEYLEN    = 5'd16;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LE     = 8'h65;
	localparam logic [7:0] CH_UE     = 8'h45;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LOW    = 8'h20;
	localparam logic [7:0] CH_HIGH   = 8'h7E;

	// Largest value that can still take another digit (2^64-1 divided by ten).
	localparam logic [63:0] INT_LIMIT = 64'h1999999999999999;

	typedef struct packed {
		logic [SW-1:0] status;
		logic [CW-1:0] offset;
	} result_t;
endpackage

// ===== rtl/core/cjsv_ram.sv =====
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module cjsv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/cjsv_parser.sv =====
// Parse state, key store and per-byte next-state logic of the validator.
`timescale 1ns / 1ps
module cjsv_parser
	import cjsv_pkg::*;
#(
	parameter int LEVELS    = LEVELS_DEF,
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     data_byte,
	input  logic           last_byte,
	input  logic [CW-1:0]  max_length,
	input  logic [DLW-1:0] depth_limit,
	output result_t        result
);
	localparam int NW  = $clog2(LEVELS + 1);
	localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int KIW = $clog2(KEY_BYTES + 1);
	localparam int AW  = $clog2(LEVELS * KEY_BYTES);
	localparam int EW  = (NW > DLW) ? NW + 1 : DLW + 1;

	localparam logic [3:0] PH_ROOT       = 4'd0;
	localparam logic [3:0] PH_OBJ_START  = 4'd1;
	localparam logic [3:0] PH_KEY_EXPECT = 4'd2;
	localparam logic [3:0] PH_KEY        = 4'd3;
	localparam logic [3:0] PH_COLON      = 4'd4;
	localparam logic [3:0] PH_VALUE      = 4'd5;
	localparam logic [3:0] PH_STRING     = 4'd6;
	localparam logic [3:0] PH_INT_ZERO   = 4'd7;
	localparam logic [3:0] PH_INT        = 4'd8;
	localparam logic [3:0] PH_AFTER_VAL  = 4'd9;
	localparam logic [3:0] PH_AFTER_ROOT = 4'd10;
	localparam logic [3:0] PH_DONE       = 4'd11;

	localparam logic [1:0] ORD_EQUAL = 2'd0;
	localparam logic [1:0] ORD_RISE  = 2'd1;
	localparam logic [1:0] ORD_FALL  = 2'd2;

	logic [3:0]      phase_q, phase_d;
	logic [NW-1:0]   nest_q, nest_d;
	logic [LEVELS-1:0] seen_q, seen_d;
	logic [KIW-1:0]  plen_q [LEVELS];
	logic            plen_we;
	logic [KIW-1:0]  idx_q, idx_d;
	logic [1:0]      ord_q, ord_d;
	logic [63:0]     ival_q, ival_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [SW-1:0]   err_q, err_d;
	logic [CW-1:0]   epos_q, epos_d;

	logic [LW-1:0]   lvl, lvl_d;
	logic [AW-1:0]   slot, slot_d;
	logic [7:0]      prev_byte;
	logic            key_we;

	logic [SW-1:0]   code1, code2;
	logic [EW-1:0]   eff;
	logic            too_deep, too_deep_end, is_dig;
	logic [63:0]     digit;

	assign lvl    = LW'(nest_q - NW'(1));
	assign lvl_d  = LW'(nest_d - NW'(1));
	assign slot   = AW'(lvl) * AW'(KEY_BYTES) + AW'(idx_q);
	assign slot_d = AW'(lvl_d) * AW'(KEY_BYTES) + AW'(idx_d);

	// Without a step the state holds, so the store keeps reading the current slot.
	cjsv_ram #(
		.WIDTH(8),
		.DEPTH(LEVELS * KEY_BYTES)
	) u_keys (
		.clk  (clk),
		.we   (key_we && step),
		.waddr(slot),
		.wdata(data_byte),
		.raddr(step ? slot_d : slot),
		.rdata(prev_byte)
	);

	always_comb begin
		eff = (EW'(depth_limit) > EW'(LEVELS)) ? EW'(LEVELS) : EW'(depth_limit);
		too_deep = EW'(nest_q) >= eff;
		is_dig = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
		digit = 64'(data_byte - CH_ZERO);
		phase_d = phase_q;
		nest_d = nest_q;
		seen_d = seen_q;
		plen_we = 1'b0;
		idx_d = idx_q;
		ord_d = ord_q;
		ival_d = ival_q;
		key_we = 1'b0;
		code1 = ST_OK;
		code2 = ST_OK;
		too_deep_end = 1'b0;
		cnt_d = (cnt_q < POS_MAX) ? cnt_q + CW'(1) : cnt_q;
		if (err_q == ST_OK) begin
			if (cnt_q >= max_length) begin
				code1 = ST_SIZE;
			end else begin
				unique case (phase_q)
					PH_ROOT, PH_VALUE: begin
						if (too_deep) begin
							code1 = ST_DEPTH;
						end else if (data_byte == CH_LBRACE) begin
							seen_d[LW'(nest_q)] = 1'b0;
							nest_d = nest_q + NW'(1);
							phase_d = PH_OBJ_START;
						end else if (data_byte == CH_QUOTE) begin
							phase_d = PH_STRING;
						end else if (data_byte == CH_ZERO) begin
							ival_d = '0;
							phase_d = PH_INT_ZERO;
						end else if (is_dig) begin
							ival_d = digit;
							phase_d = PH_INT;
						end else begin
							code1 = ST_VALUE;
						end
					end
					PH_OBJ_START, PH_KEY_EXPECT: begin
						if (phase_q == PH_OBJ_START && data_byte == CH_RBRACE) begin
							nest_d = nest_q - NW'(1);
							phase_d = (nest_d == '0) ? PH_AFTER_ROOT : PH_AFTER_VAL;
						end else if (data_byte == CH_QUOTE) begin
							idx_d = '0;
							ord_d = ORD_EQUAL;
							phase_d = PH_KEY;
						end else begin
							code1 = ST_KEYSTR;
						end
					end
					PH_KEY: begin
						if (data_byte == CH_QUOTE) begin
							if (seen_q[lvl] && (ord_q == ORD_FALL ||
									(ord_q == ORD_EQUAL && idx_q <= plen_q[lvl]))) begin
								code1 = ST_ORDER;
							end else begin
								plen_we = 1'b1;
								seen_d[lvl] = 1'b1;
								phase_d = PH_COLON;
							end
						end else if (data_byte == CH_BSLASH) begin
							code1 = ST_ESCAPE;
						end else if (data_byte < CH_LOW || data_byte > CH_HIGH) begin
							code1 = ST_UNPRINT;
						end else if (idx_q >= KIW'(KEY_BYTES)) begin
							code1 = ST_KEYLEN;
						end else begin
							// The stored byte at this slot was prefetched last cycle.
							if (seen_q[lvl] && ord_q == ORD_EQUAL) begin
								if (idx_q < plen_q[lvl]) begin
									if (data_byte > prev_byte) begin
										ord_d = ORD_RISE;
									end else if (data_byte < prev_byte) begin
										ord_d = ORD_FALL;
									end
								end else begin
									ord_d = ORD_RISE;
								end
							end
							key_we = 1'b1;
							idx_d = idx_q + KIW'(1);
						end
					end
					PH_COLON: begin
						if (data_byte == CH_COLON) begin
							phase_d = PH_VALUE;
						end else begin
							code1 = ST_COLON;
						end
					end
					PH_STRING: begin
						if (data_byte == CH_QUOTE) begin
							phase_d = PH_AFTER_VAL;
						end else if (data_byte == CH_BSLASH) begin
							code1 = ST_ESCAPE;
						end else if (data_byte < CH_LOW || data_byte > CH_HIGH) begin
							code1 = ST_UNPRINT;
						end
					end
					PH_INT_ZERO, PH_INT, PH_AFTER_VAL: begin
						if (is_dig && phase_q == PH_INT_ZERO) begin
							code1 = ST_LEADZERO;
						end else if (is_dig && phase_q == PH_INT) begin
							if (ival_q > INT_LIMIT ||
									(ival_q == INT_LIMIT && data_byte > 8'h35)) begin
								code1 = ST_RANGE;
							end else begin
								ival_d = (ival_q << 3) + (ival_q << 1) + digit;
							end
						end else if (phase_q != PH_AFTER_VAL &&
								(data_byte == CH_DOT || data_byte == CH_LE ||
								data_byte == CH_UE)) begin
							code1 = ST_FRACTION;
						end else begin
							phase_d = PH_AFTER_VAL;
							if (nest_q == '0) begin
								code1 = ST_ROOT;
							end else if (data_byte == CH_COMMA) begin
								phase_d = PH_KEY_EXPECT;
							end else if (data_byte == CH_RBRACE) begin
								nest_d = nest_q - NW'(1);
								phase_d = (nest_d == '0) ? PH_AFTER_ROOT : PH_AFTER_VAL;
							end else begin
								code1 = ST_SEPARATOR;
							end
						end
					end
					PH_AFTER_ROOT: begin
						if (data_byte == CH_NL) begin
							phase_d = PH_DONE;
						end else begin
							code1 = ST_TRAILING;
						end
					end
					default: code1 = ST_TRAILING;
				endcase
			end
		end
		// Checks that apply when the document stops at this byte.
		if (last_byte && err_q == ST_OK && code1 == ST_OK) begin
			too_deep_end = EW'(nest_d) >= eff;
			unique case (phase_d)
				PH_OBJ_START, PH_KEY_EXPECT: code2 = ST_KEYSTR;
				PH_KEY, PH_STRING:           code2 = ST_UNTERM;
				PH_COLON:                    code2 = ST_COLON;
				PH_ROOT, PH_VALUE:           code2 = too_deep_end ? ST_DEPTH : ST_VALUE;
				PH_INT_ZERO, PH_INT, PH_AFTER_VAL:
					code2 = (nest_d == '0) ? ST_ROOT : ST_SEPARATOR;
				PH_AFTER_ROOT:               code2 = ST_TRAILING;
				default:                     code2 = ST_OK;
			endcase
		end
		err_d = err_q;
		epos_d = epos_q;
		if (err_q == ST_OK && code1 != ST_OK) begin
			err_d = code1;
			epos_d = cnt_q;
		end else if (err_q == ST_OK && code2 != ST_OK) begin
			err_d = code2;
			epos_d = cnt_d;
		end
		result.status = err_d;
		result.offset = (err_d == ST_OK) ? '0 : epos_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ROOT;
			nest_q <= '0;
			seen_q <= '0;
			idx_q <= '0;
			ord_q <= ORD_EQUAL;
			ival_q <= '0;
			cnt_q <= '0;
			err_q <= ST_OK;
			epos_q <= '0;
		end else if (step && last_byte) begin
			phase_q <= PH_ROOT;
			nest_q <= '0;
			seen_q <= '0;
			idx_q <= '0;
			ord_q <= ORD_EQUAL;
			ival_q <= '0;
			cnt_q <= '0;
			err_q <= ST_OK;
			epos_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			nest_q <= nest_d;
			seen_q <= seen_d;
			idx_q <= idx_d;
			ord_q <= ord_d;
			ival_q <= ival_d;
			cnt_q <= cnt_d;
			err_q <= err_d;
			epos_q <= epos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && plen_we) begin
			plen_q[lvl] <= idx_q;
		end
	end

	`include "assert_macros.svh"

	`CJSV_ASSERT(a_nest_range, clk, arst_n, nest_q <= NW'(LEVELS))
	`CJSV_ASSERT(a_key_write_in_key, clk, arst_n, !key_we || phase_q == PH_KEY)
	`CJSV_ASSERT_NEXT(a_error_sticky, clk, arst_n, err_q != ST_OK && !(step && last_byte), err_q == $past(err_q))
	`CJSV_ASSERT(a_key_index_bound, clk, arst_n, idx_q <= KIW'(KEY_BYTES))
endmodule

// ===== rtl/core/canonical_json_stream_validator_core.sv =====
// Top level: input register, config registers, parser and result register.
// A last byte's verdict is registered when the byte steps; it stalls while a result is held.
// Throughput: one byte per cycle otherwise; key store reads run the cycle before key bytes.
// Only a last byte produces a result beat.
// Reset clears parse state and sets max_length to 65536 and depth_limit to 8.
`timescale 1ns / 1ps
module canonical_json_stream_validator_core
	import cjsv_pkg::*;
#(
	parameter int LEVELS    = LEVELS_DEF,
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [CW-1:0] cfg_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [SW-1:0] status,
	output logic [CW-1:0] error_offset
);
	logic [CW-1:0]  max_len_q;
	logic [DLW-1:0] depth_q;
	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           last_s1;
	logic           step;
	result_t        res;

	// A byte moves on unless it would produce a result while the output still holds one.
	assign step     = valid_s1 && !(last_s1 && out_valid && out_stall);
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAXLEN_RST;
			depth_q <= DEPTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_LENGTH:  max_len_q <= cfg_data;
				REG_DEPTH_LIMIT: depth_q <= cfg_data[DLW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	cjsv_parser #(
		.LEVELS(LEVELS),
		.KEY_BYTES(KEY_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (byte_s1),
		.last_byte  (last_s1),
		.max_length (max_len_q),
		.depth_limit(depth_q),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (step && last_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			status <= res.status;
			error_offset <= res.offset;
		end
	end
endmodule
